>>> rtl/core/open_addressing_hash_table_core_defines.svh
// Assertion helpers for the hash table core
`ifndef OPEN_ADDRESSING_HASH_TABLE_CORE_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_CORE_DEFINES_SVH

// a condition implies a consequence on the same edge
`define OAHT_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// a condition implies a consequence on the next edge
`define OAHT_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/oaht_pkg.sv
package oaht_pkg;

    localparam int unsigned CFG_W = 7;

    typedef enum logic [0:0] {
        REG_TABLE_SIZE    = 1'b0,
        REG_PROBING_MODE  = 1'b1
    } t_reg_idx;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_PROBE  = 2'd2;
    localparam logic [1:0] CMD_DUMP   = 2'd3;

    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_PROBE     = 3'd4;
    localparam logic [2:0] ST_USAGE     = 3'd5;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [62:0]        key_chars;
        logic [3:0]         key_length;
        logic signed [31:0] value;
        logic [7:0]         probe_number;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [5:0]         slot_index;
        logic signed [31:0] found_value;
        logic [6:0]         probe_count;
        logic               last;
    } t_out_item;

endpackage

>>> rtl/core/open_addressing_hash_table_core.sv
// Hashing walks the key one character at a time; each probe then passes address, read and compare.
// Insert/lookup stop at a free slot, a key match or after table_size probes; probe query only steps the probes.
// Usage dump: one line per slot, with the probe count at which an occupied slot's stored key reaches it.
// One item in flight at a time; the next is accepted after the last result leaves.
// Synchronous active-low reset clears control state, then a pass over all SLOTS entries
// clears occupancy; no item is accepted during that pass.
`include "open_addressing_hash_table_core_defines.svh"
module open_addressing_hash_table_core #(
    parameter int SLOTS      = 64,
    parameter int KEY_CHARS  = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [oaht_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  oaht_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output oaht_pkg::t_out_item  o_out_data
);
    import oaht_pkg::*;

    localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KW   = 7 * KEY_CHARS;
    localparam int LW   = 4;
    localparam int CW   = AW + 1;     // counts up to SLOTS
    localparam int ENT_W = KW + LW + VALUE_BITS;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_HASH   = 10'b0000000100,
        S_ADDR   = 10'b0000001000,
        S_READ   = 10'b0000010000,
        S_CHECK  = 10'b0000100000,
        S_OUT    = 10'b0001000000,
        S_DREAD  = 10'b0010000000,
        S_DHASH  = 10'b0100000000,
        S_DCHECK = 10'b1000000000
    } t_state;

    t_state r_state;

    // configuration
    logic [6:0] r_table_size;
    logic       r_probing_mode;
    logic [CW-1:0] w_size;
    always_comb begin
        if (r_table_size == 7'd0)
            w_size = CW'(1);
        else if (r_table_size > 7'(SLOTS))
            w_size = CW'(SLOTS);
        else
            w_size = CW'(r_table_size);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size   <= 7'(64);
            r_probing_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_TABLE_SIZE:   r_table_size   <= i_cfg_data[6:0];
                REG_PROBING_MODE: r_probing_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // memories: occupancy bit and entry (key, length, value)
    logic             occ_mem [SLOTS];
    logic [ENT_W-1:0] ent_mem [SLOTS];
    logic             r_occ_rd;
    logic [ENT_W-1:0] r_ent_rd;
    logic             w_mem_we;
    logic             w_occ_wd;
    logic [AW-1:0]    w_mem_wa;
    logic [AW-1:0]    w_mem_ra;
    logic             w_ent_we;
    logic [ENT_W-1:0] w_ent_wd;

    always_ff @(posedge i_clk) begin
        if (w_mem_we)
            occ_mem[w_mem_wa] <= w_occ_wd;
        if (w_ent_we)
            ent_mem[w_mem_wa] <= w_ent_wd;
        r_occ_rd <= occ_mem[w_mem_ra];
        r_ent_rd <= ent_mem[w_mem_ra];
    end

    // working registers
    logic [1:0]          r_cmd;
    logic [KW-1:0]       r_key;       // item key, masked and packed 7 bits per char
    logic [LW-1:0]       r_len;
    logic [VALUE_BITS-1:0] r_val;
    logic [7:0]          r_probe_num;
    logic [7:0]          r_pn;        // probe query count
    logic [KW-1:0]       r_hkey;      // key being hashed
    logic [LW-1:0]       r_hlen;
    logic [LW-1:0]       r_hn;
    logic [AW-1:0]       r_h;
    logic [CW-1:0]       r_i;         // probe index
    logic [AW-1:0]       r_step;      // triangular offset mod size
    logic [AW-1:0]       r_addr;
    logic [CW-1:0]       r_slot;      // dump slot / clear pointer
    t_out_item           r_out;

    // key extraction with length clamp
    logic [LW-1:0] w_in_len;
    logic [KW-1:0] w_in_key;
    always_comb begin
        if (i_in_data.key_length == 4'd0)
            w_in_len = LW'(1);
        else if (i_in_data.key_length > 4'(KEY_CHARS))
            w_in_len = LW'(KEY_CHARS);
        else
            w_in_len = i_in_data.key_length;
        for (int n = 0; n < KEY_CHARS; n++)
            w_in_key[7*n +: 7] = (LW'(n) < w_in_len) ? i_in_data.key_chars[8*n +: 7] : 7'd0;
    end

    // one hash step: h*128 + c mod size, via a 14-bit remainder by successive compare
    // the value is below 128*size, so seven conditional subtractions of size<<k
    logic [6:0]  w_char;
    logic [13:0] w_hv;
    logic [AW-1:0] w_hnext;
    always_comb begin
        logic [13:0] t;
        w_char = r_hkey[7*r_hn[2:0] +: 7];
        t = {r_h, 7'd0} + 14'(w_char);
        for (int k = 6; k >= 0; k--) begin
            if (t >= (14'(w_size) << k))
                t = t - (14'(w_size) << k);
        end
        w_hv = t;
        w_hnext = w_hv[AW-1:0];
    end

    // probe address: h + step mod size; both below size
    function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] a, input logic [AW-1:0] b,
                                              input logic [CW-1:0] m);
        logic [CW:0] s;
        s = {1'b0, CW'(a)} + {1'b0, CW'(b)};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[AW-1:0];
    endfunction

    // wrap an index below 2*size into range
    logic [CW-1:0] w_i_mod;
    logic [AW-1:0] w_lin_step;
    assign w_i_mod = (r_i >= w_size) ? r_i - w_size : r_i;
    assign w_lin_step = w_i_mod[AW-1:0];
    logic [AW-1:0] w_step;
    assign w_step = r_probing_mode ? r_step : w_lin_step;
    logic [AW-1:0] w_paddr;
    assign w_paddr = mod_add(r_h, w_step, w_size);
    // next triangular offset: step(i+1) = step(i) + i + 1
    logic [AW-1:0] w_step_next;
    logic [CW-1:0] w_ip1;
    logic [CW-1:0] w_ip1_mod;
    assign w_ip1 = r_i + CW'(1);
    assign w_ip1_mod = (w_ip1 >= w_size) ? w_ip1 - w_size : w_ip1;
    assign w_step_next = mod_add(r_step, w_ip1_mod[AW-1:0], w_size);

    // key match on stored key and length; the probe query counter r_pn walks to probe_number
    logic w_key_match;
    assign w_key_match = (r_ent_rd[ENT_W-1 -: KW] == r_key)
                      && (r_ent_rd[VALUE_BITS +: LW] == r_len);

    logic w_in_acc;
    logic w_out_acc;
    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data = r_out;

    logic w_hash_done;
    assign w_hash_done = (r_hn + LW'(1) >= r_hlen);

    // memory port control
    always_comb begin
        w_mem_we = 1'b0;
        w_ent_we = 1'b0;
        w_occ_wd = 1'b0;
        w_mem_wa = r_addr;
        w_mem_ra = r_addr;
        w_ent_wd = {r_key, r_len, r_val};
        if (r_state == S_CLEAR) begin
            w_mem_we = 1'b1;
            w_mem_wa = r_slot[AW-1:0];
        end else if (r_state == S_CHECK && r_cmd == CMD_INSERT
                     && (!r_occ_rd || w_key_match)) begin
            w_mem_we = 1'b1;
            w_ent_we = 1'b1;
            w_occ_wd = 1'b1;
        end
        if (r_state == S_DREAD || r_state == S_OUT)
            w_mem_ra = r_slot[AW-1:0];
    end

    logic signed [31:0] w_val_out;
    assign w_val_out = 32'($signed(r_ent_rd[VALUE_BITS-1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_slot  <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (r_slot == CW'(SLOTS - 1)) begin
                        r_state <= S_IDLE;
                        r_slot  <= '0;
                    end else begin
                        r_slot <= r_slot + CW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_cmd       <= i_in_data.cmd;
                        r_key       <= w_in_key;
                        r_len       <= w_in_len;
                        r_val       <= VALUE_BITS'(i_in_data.value);
                        r_probe_num <= i_in_data.probe_number;
                        r_pn        <= '0;
                        r_hkey      <= w_in_key;
                        r_hlen      <= w_in_len;
                        r_hn        <= '0;
                        r_h         <= '0;
                        r_i         <= '0;
                        r_step      <= '0;
                        r_slot      <= '0;
                        r_state     <= (i_in_data.cmd == CMD_DUMP) ? S_DREAD : S_HASH;
                    end
                end
                S_HASH: begin
                    r_h  <= w_hnext;
                    r_hn <= r_hn + LW'(1);
                    if (w_hash_done)
                        r_state <= S_ADDR;
                end
                S_ADDR: begin
                    // r_i is the current probe; r_step follows it
                    if (r_cmd == CMD_PROBE) begin
                        // r_i holds the probe index mod size
                        if (r_pn == r_probe_num) begin
                            r_out <= '{ST_PROBE, 6'(w_paddr), 32'sd0, 7'd0, 1'b1};
                            r_state <= S_OUT;
                        end else begin
                            r_pn   <= r_pn + 8'd1;
                            r_step <= w_step_next;
                            r_i    <= w_ip1_mod;
                        end
                    end else if (r_cmd == CMD_DUMP) begin
                        if (w_paddr == r_slot[AW-1:0]) begin
                            r_out <= '{ST_USAGE, 6'(r_slot), 32'sd0, 7'(r_i + CW'(1)),
                                       (r_slot + CW'(1) == w_size)};
                            r_state <= S_OUT;
                        end else if (r_i + CW'(1) >= w_size) begin
                            r_out <= '{ST_USAGE, 6'(r_slot), 32'sd0, 7'(w_size + CW'(1)),
                                       (r_slot + CW'(1) == w_size)};
                            r_state <= S_OUT;
                        end else begin
                            r_step <= w_step_next;
                            r_i    <= w_ip1;
                        end
                    end else begin
                        if (r_i >= w_size) begin
                            r_out <= (r_cmd == CMD_INSERT)
                                   ? '{ST_FULL, 6'd0, 32'sd0, 7'd0, 1'b1}
                                   : '{ST_NOT_FOUND, 6'd0, 32'sd0, 7'd0, 1'b1};
                            r_state <= S_OUT;
                        end else begin
                            r_addr  <= w_paddr;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: r_state <= S_CHECK;
                S_CHECK: begin
                    if (r_cmd == CMD_INSERT && (!r_occ_rd || w_key_match)) begin
                        r_out <= '{ST_STORED, 6'(r_addr), 32'sd0, 7'd0, 1'b1};
                        r_state <= S_OUT;
                    end else if (r_cmd == CMD_LOOKUP && !r_occ_rd) begin
                        r_out <= '{ST_NOT_FOUND, 6'd0, 32'sd0, 7'd0, 1'b1};
                        r_state <= S_OUT;
                    end else if (r_cmd == CMD_LOOKUP && w_key_match) begin
                        r_out <= '{ST_FOUND, 6'(r_addr), w_val_out, 7'd0, 1'b1};
                        r_state <= S_OUT;
                    end else begin
                        r_step  <= w_step_next;
                        r_i     <= w_ip1;
                        r_state <= S_ADDR;
                    end
                end
                S_DREAD: r_state <= S_DHASH;
                S_DHASH: begin
                    // memory output holds the dump slot's entry
                    if (!r_occ_rd) begin
                        r_out <= '{ST_USAGE, 6'(r_slot), 32'sd0, 7'd0,
                                   (r_slot + CW'(1) == w_size)};
                        r_state <= S_OUT;
                    end else begin
                        r_hkey  <= r_ent_rd[ENT_W-1 -: KW];
                        r_hlen  <= r_ent_rd[VALUE_BITS +: LW];
                        r_hn    <= '0;
                        r_h     <= '0;
                        r_i     <= '0;
                        r_step  <= '0;
                        r_state <= S_HASH;
                    end
                end
                S_OUT: begin
                    if (w_out_acc) begin
                        if (r_cmd == CMD_DUMP && !r_out.last) begin
                            r_slot  <= r_slot + CW'(1);
                            r_state <= S_DREAD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DCHECK: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `OAHT_ASSERT_IMP(a_out_only_in_out, i_clk, i_rst_n, o_out_valid, o_in_stall, "output while idle")
    `OAHT_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, w_out_acc && r_out.last, r_state == S_IDLE, "last did not end item")
    `OAHT_ASSERT_IMP(a_in_idle, i_clk, i_rst_n, w_in_acc, r_state == S_IDLE, "accept while busy")

endmodule
